### hw/rtl/lrcv_pkg.sv
// ----------------------------------------------------------------------------
// lrcv_pkg
// Types, constants and CRC/float helpers for the record CRC validator.
// ----------------------------------------------------------------------------
`default_nettype none
package lrcv_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RECORD_MAGIC = 3'd0,
    CFG_HIBERNATE    = 3'd1,
    CFG_BATT_MIN     = 3'd2,
    CFG_BATT_MAX     = 3'd3,
    CFG_CHARGE_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FAIL_NONE    = 3'd0,
    FAIL_MAGIC   = 3'd1,
    FAIL_CRC     = 3'd2,
    FAIL_BATTERY = 3'd3,
    FAIL_CHARGE  = 3'd4
  } fail_e;

  typedef enum logic [1:0] {
    BOOT_COLD      = 2'd0,
    BOOT_CORRUPT   = 2'd1,
    BOOT_HIBERNATE = 2'd2
  } boot_e;

  localparam logic        CMD_CHECK       = 1'b1;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES    = 32'hFFFFFFFF;
  localparam logic [31:0] RESET_MAGIC     = 32'hEA51C0DE;
  localparam logic [31:0] RESET_BATT_MIN  = 32'h40A00000;
  localparam logic [31:0] RESET_BATT_MAX  = 32'h41100000;
  localparam logic [7:0]  RESET_CHARGE    = 8'd100;
  localparam logic [15:0] BUILD_RESERVED  = 16'hFFFF;

  typedef struct packed {
    logic        command;
    logic [31:0] magic_word;
    logic [7:0]  state_code;
    logic [7:0]  charge_percent;
    logic [15:0] reserved_bytes;
    logic [31:0] battery_bits;
    logic [31:0] solar_bits;
    logic [31:0] stored_crc;
  } in_item_t;

  typedef struct packed {
    logic [31:0] computed_crc;
    logic        record_valid;
    logic [2:0]  failure;
    logic [1:0]  boot_reason;
    logic        erase_request;
  } out_item_t;

  typedef struct packed {
    logic [31:0] record_magic;
    logic [7:0]  hibernate_code;
    logic [31:0] battery_min_bits;
    logic [31:0] battery_max_bits;
    logic [7:0]  charge_limit;
  } cfg_t;

  // classified record passed from front to back
  typedef struct packed {
    logic        check;
    logic [31:0] crc;
    logic [31:0] stored_crc;
    logic        magic_ok;
    logic        batt_ok;
    logic        charge_ok;
    logic        hibernate;
  } entry_t;

  function automatic logic [31:0] crc_word(input logic [31:0] crc_in,
                                           input logic [31:0] word);
    logic [31:0] c;
    c = crc_in ^ word;
    for (int b = 0; b < 32; b++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  // a < b as IEEE single; false if either is NaN
  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic a_nan, b_nan, a_zero, b_zero, res;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    if (a_nan || b_nan || (a_zero && b_zero)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/lrcv_front.sv
// ----------------------------------------------------------------------------
// lrcv_front
// Accepts records, seals or checks them, computes CRC and range tests.
// ----------------------------------------------------------------------------
`default_nettype none
module lrcv_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lrcv_pkg::cfg_t   cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire lrcv_pkg::in_item_t in_data_i,
  output logic                  ent_valid_o,
  input  wire logic             ent_ready_i,
  output lrcv_pkg::entry_t      ent_o
);
  import lrcv_pkg::*;

  logic        valid_q;
  entry_t      ent_q, ent_d;
  logic [31:0] magic, w1, c;
  logic [15:0] rsv;
  logic        chk;

  assign in_ready_o  = !valid_q || ent_ready_i;
  assign ent_valid_o = valid_q;
  assign ent_o       = ent_q;

  always_comb begin
    chk   = (in_data_i.command == CMD_CHECK);
    magic = chk ? in_data_i.magic_word : cfg_i.record_magic;
    rsv   = chk ? in_data_i.reserved_bytes : BUILD_RESERVED;
    w1    = {rsv, in_data_i.charge_percent, in_data_i.state_code};
    c = crc_word(CRC_ALL_ONES, magic);
    c = crc_word(c, w1);
    c = crc_word(c, in_data_i.battery_bits);
    c = crc_word(c, in_data_i.solar_bits);
    ent_d.check      = chk;
    ent_d.crc        = c ^ CRC_ALL_ONES;
    ent_d.stored_crc = in_data_i.stored_crc;
    ent_d.magic_ok   = (magic == cfg_i.record_magic);
    ent_d.batt_ok    = !(fp_lt(in_data_i.battery_bits, cfg_i.battery_min_bits) ||
                         fp_lt(cfg_i.battery_max_bits, in_data_i.battery_bits));
    ent_d.charge_ok  = (in_data_i.charge_percent <= cfg_i.charge_limit);
    ent_d.hibernate  = (in_data_i.state_code == cfg_i.hibernate_code);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ent_q <= ent_d;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/lrcv_fifo.sv
// ----------------------------------------------------------------------------
// lrcv_fifo
// Short queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module lrcv_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_valid_i,
  output logic                 wr_ready_o,
  input  wire lrcv_pkg::entry_t wr_data_i,
  output logic                 rd_valid_o,
  input  wire logic            rd_ready_i,
  output lrcv_pkg::entry_t     rd_data_o
);
  import lrcv_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  entry_t                 mem_q [Depth];
  logic [PtrW-1:0]        wptr_q, rptr_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;
  logic                   push, pop;

  assign wr_ready_o = (cnt_q != Depth[$clog2(Depth+1)-1:0]);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + {{($clog2(Depth+1)-1){1'b0}}, push}
                     - {{($clog2(Depth+1)-1){1'b0}}, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/lrcv_back.sv
// ----------------------------------------------------------------------------
// lrcv_back
// Resolves the first failure and drives the registered result.
// ----------------------------------------------------------------------------
`default_nettype none
module lrcv_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             ent_valid_i,
  output logic                  ent_ready_o,
  input  wire lrcv_pkg::entry_t ent_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output lrcv_pkg::out_item_t   out_data_o
);
  import lrcv_pkg::*;

  logic      valid_q;
  out_item_t res_q, res_d;
  fail_e     fail;

  assign ent_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

  always_comb begin
    if (!ent_i.magic_ok) begin
      fail = FAIL_MAGIC;
    end else if (ent_i.stored_crc != ent_i.crc) begin
      fail = FAIL_CRC;
    end else if (!ent_i.batt_ok) begin
      fail = FAIL_BATTERY;
    end else if (!ent_i.charge_ok) begin
      fail = FAIL_CHARGE;
    end else begin
      fail = FAIL_NONE;
    end
    res_d.computed_crc  = ent_i.crc;
    res_d.record_valid  = 1'b1;
    res_d.failure       = FAIL_NONE;
    res_d.boot_reason   = BOOT_COLD;
    res_d.erase_request = 1'b0;
    if (ent_i.check) begin
      res_d.failure = fail;
      if (fail != FAIL_NONE) begin
        res_d.record_valid = 1'b0;
        res_d.boot_reason  = ent_i.magic_ok ? BOOT_CORRUPT : BOOT_COLD;
      end else begin
        res_d.boot_reason   = ent_i.hibernate ? BOOT_HIBERNATE : BOOT_COLD;
        res_d.erase_request = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ent_ready_o) begin
      valid_q <= ent_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_ready_o && ent_valid_i) begin
      res_q <= res_d;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/log_record_crc_validator_top.sv
// ----------------------------------------------------------------------------
// log_record_crc_validator_top
// Seals or checks a CRC-32 protected saved-state record.
// ----------------------------------------------------------------------------
// With an empty queue, a result passes the front register, the queue and the result register.
// Throughput: one record per cycle while out_ready_i is not held low; CRC is a combinational XOR network.
// Reset clears the pipeline and queue and loads register defaults.
`default_nettype none
module log_record_crc_validator_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [31:0]           cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire lrcv_pkg::in_item_t    in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output lrcv_pkg::out_item_t        out_data_o
);
  import lrcv_pkg::*;

  cfg_t   cfg_q;
  entry_t f_ent, q_ent;
  logic   f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.record_magic     <= RESET_MAGIC;
      cfg_q.hibernate_code   <= 8'd0;
      cfg_q.battery_min_bits <= RESET_BATT_MIN;
      cfg_q.battery_max_bits <= RESET_BATT_MAX;
      cfg_q.charge_limit     <= RESET_CHARGE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RECORD_MAGIC: cfg_q.record_magic     <= cfg_data_i;
        CFG_HIBERNATE:    cfg_q.hibernate_code   <= cfg_data_i[7:0];
        CFG_BATT_MIN:     cfg_q.battery_min_bits <= cfg_data_i;
        CFG_BATT_MAX:     cfg_q.battery_max_bits <= cfg_data_i;
        CFG_CHARGE_LIMIT: cfg_q.charge_limit     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  lrcv_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i, .in_ready_o, .in_data_i,
    .ent_valid_o(f_valid), .ent_ready_i(f_ready), .ent_o(f_ent)
  );

  lrcv_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_ent),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_ent)
  );

  lrcv_back u_back (
    .clk_i, .rst_ni,
    .ent_valid_i(q_valid), .ent_ready_o(q_ready), .ent_i(q_ent),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule
`default_nettype wire

### hw/rtl/lrcv_checker.sv
// ----------------------------------------------------------------------------
// lrcv_assert
// Port-level assertions for the record CRC validator.
// ----------------------------------------------------------------------------
`default_nettype none
module lrcv_assert (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire lrcv_pkg::out_item_t out_data_o
);
  import lrcv_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");

  a_valid_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.record_valid == (out_data_o.failure == FAIL_NONE)))
    else $error("valid flag and failure disagree");

  a_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.erase_request |-> out_data_o.record_valid)
    else $error("erase without valid record");

  a_corrupt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.boot_reason == BOOT_CORRUPT
      |-> out_data_o.failure != FAIL_MAGIC && out_data_o.failure != FAIL_NONE)
    else $error("corrupt boot with wrong failure");
endmodule

bind log_record_crc_validator_top lrcv_assert u_assert (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire
